// ===== design/assert_macros.svh =====
// assertion macros used by the top level design file
// no dependencies; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cplm_pkg.sv =====
// package for the call sign prefix match engine: beat types, codes, helpers
// no dependencies
package cplm_pkg;

	localparam int TABLE_DEPTH_DEF   = 4096;
	localparam int MAX_KEY_CHARS_DEF = 8;
	localparam int ENTITY_COUNT_DEF  = 1024;
	localparam int PAIR_SLOTS        = 1296;
	localparam int PAIR_W            = 11;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] KIND_PAIR  = 2'd0;
	localparam logic [1:0] KIND_WHOLE = 2'd1;
	localparam logic [1:0] KIND_SHORT = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] key_chars;
		logic [3:0]  key_length;
		logic        exact_only;
		logic [9:0]  entity;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  match_kind;
		logic [11:0] entry_index;
		logic [9:0]  entity_out;
	} res_t;

	typedef struct packed {
		logic [63:0] key;
		logic [3:0]  len;
		logic        exact;
		logic [9:0]  ent;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sweep;
		logic ins_rd;
		logic ins_wr;
		logic q_ent;
		logic q_chk;
		logic scan;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic sweep_last;
		logic slot_hit;
		logic scan_more;
	} sts_t;

	// mask of the low len bytes
	function automatic logic [63:0] char_mask(input logic [3:0] len);
		logic [63:0] m;
		if (len >= 4'd8)
			m = '1;
		else
			m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
		return m;
	endfunction

	function automatic logic [5:0] base36(input logic [7:0] c);
		logic [5:0] v;
		if (c >= "0" && c <= "9")
			v = 6'(c - "0");
		else if (c >= "A" && c <= "Z")
			v = 6'(c - "A" + 8'd10);
		else
			v = 6'd0;
		return v;
	endfunction

	// base-36 value of the first two characters, always below 1296
	function automatic logic [PAIR_W-1:0] pair_index(input logic [63:0] key);
		logic [PAIR_W-1:0] b0, b1;
		b0 = PAIR_W'(base36(key[7:0]));
		b1 = PAIR_W'(base36(key[15:8]));
		return b0 + (b1 << 5) + (b1 << 2);
	endfunction

endpackage

// ===== design/callsign_prefix_longest_match.sv =====
// top level of the call sign prefix match engine
// depends on cplm_pkg, cplm_ctrl, cplm_datapath, assert_macros.svh
//
// channel   | handshake            | payload
// command   | start, busy          | cmd (cmd_t)
// result    | done                 | result (res_t)
//
// clear: sweeps all pair slots back to unused, one pair slot per cycle
// insert: INS_RD, INS_WR, FIN, or FIN alone when full; unused opcode: FIN alone
// query: Q_SLOT, Q_ENT, Q_CHK, FIN on a pair slot hit, otherwise SCAN reads
// every stored entry through the single read port of the entry store before FIN
// after reset a pass over all pair slots marks them unused; busy stays high
// a result beat is shown on done for one cycle; the receiver cannot stall it
`include "assert_macros.svh"
module callsign_prefix_longest_match import cplm_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF,
	parameter int ENTITY_COUNT  = ENTITY_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	ctl_t ctl;
	sts_t sts;

	cplm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (cmd.opcode),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	cplm_datapath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.MAX_KEY_CHARS (MAX_KEY_CHARS),
		.ENTITY_COUNT  (ENTITY_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

	// checks
	`ASSERT_CLK(a_done_single, done |=> !done, "result beat longer than one cycle")
	`ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
	`ASSERT_CLK(a_notfound_clean, (done && result.status == ST_NOTFOUND) |-> (result.entry_index == 12'd0 && result.entity_out == 10'd0), "not found leaks an entry")
	`ASSERT_ALWAYS(a_reset_busy, !arst_n |=> busy || !arst_n, "idle right after reset")

endmodule

// ===== design/cplm_ctrl.sv =====
// controller state machine of the prefix match engine
// depends on cplm_pkg
module cplm_ctrl import cplm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       busy,
	output logic       done
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CLR    = 4'd2;
	localparam logic [3:0] S_INS_RD = 4'd3;
	localparam logic [3:0] S_INS_WR = 4'd4;
	localparam logic [3:0] S_Q_SLOT = 4'd5;
	localparam logic [3:0] S_Q_ENT  = 4'd6;
	localparam logic [3:0] S_Q_CHK  = 4'd7;
	localparam logic [3:0] S_SCAN   = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q, state_d;
	logic       done_q;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_CLEAR:  state_d = S_CLR;
						OP_INSERT: state_d = sts.full ? S_FIN : S_INS_RD;
						OP_QUERY:  state_d = S_Q_SLOT;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_CLR: begin
				if (sts.sweep_last) state_d = S_FIN;
			end
			S_INS_RD: state_d = S_INS_WR;
			S_INS_WR: state_d = S_FIN;
			S_Q_SLOT: state_d = S_Q_ENT;
			S_Q_ENT:  state_d = S_Q_CHK;
			S_Q_CHK:  state_d = sts.slot_hit ? S_FIN : S_SCAN;
			S_SCAN: begin
				if (!sts.scan_more) state_d = S_FIN;
			end
			S_FIN:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		ctl        = '0;
		ctl.load   = accept;
		ctl.sweep  = (state_q == S_INIT) || (state_q == S_CLR);
		ctl.ins_rd = (state_q == S_INS_RD);
		ctl.ins_wr = (state_q == S_INS_WR);
		ctl.q_ent  = (state_q == S_Q_ENT);
		ctl.q_chk  = (state_q == S_Q_CHK);
		ctl.scan   = (state_q == S_SCAN);
		ctl.finish = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

endmodule

// ===== design/cplm_datapath.sv =====
// datapath of the prefix match engine: entry store, pair slots, scan logic
// depends on cplm_pkg
module cplm_datapath import cplm_pkg::*; #(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF,
	parameter int ENTITY_COUNT  = ENTITY_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  ctl_t ctl,
	output sts_t sts,
	output res_t result
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;
	localparam int SW = IW + 2;
	localparam int NL = MAX_KEY_CHARS - 1;

	localparam logic [SW-1:0] SLOT_UNUSED = {2'b10, {IW{1'b0}}};
	localparam logic [SW-1:0] SLOT_AMBIG  = {2'b01, {IW{1'b0}}};

	// latched command
	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [3:0]  len_q;
	logic        exact_q;
	logic [9:0]  ent_q;
	logic        full_q;
	logic [IW-1:0] idx_q;

	logic [CW-1:0]     cnt_q;
	logic [PAIR_W-1:0] sweep_q;
	logic [CW-1:0]     scan_q;

	// memories
	entry_t        ent_mem [TABLE_DEPTH];
	logic [SW-1:0] slot_mem [PAIR_SLOTS];
	entry_t        ent_rd_q;
	logic [SW-1:0] slot_rd_q;

	logic [PAIR_W-1:0] pair;
	logic [IW-1:0]     ent_ra;
	logic [3:0]        len_n;
	logic [9:0]        ent_n;

	// slot check
	logic          slot_pre_q;
	logic [IW-1:0] slot_w_q;
	logic          slot_hit;
	logic          slot_hit_q;
	logic [9:0]    slot_ent_q;

	// scan pipeline
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          whole_hit_q;
	logic [IW-1:0] whole_idx_q;
	logic [9:0]    whole_ent_q;
	logic          sfound_q [NL];
	logic          sexact_q [NL];
	logic [IW-1:0] sidx_q [NL];
	logic [9:0]    sent_q [NL];

	res_t res_q, res_d;

	assign pair  = pair_index(key_q);
	assign len_n = (32'(cmd.key_length) > MAX_KEY_CHARS) ? 4'(MAX_KEY_CHARS) : cmd.key_length;
	assign ent_n = (32'(cmd.entity) >= ENTITY_COUNT) ? 10'(ENTITY_COUNT - 1) : cmd.entity;
	assign ent_ra = ctl.q_ent ? slot_rd_q[IW-1:0] : IW'(scan_q - CW'(1));

	assign slot_hit = slot_pre_q &&
		(!ent_rd_q.exact || (ent_rd_q.len == len_q && ent_rd_q.key == key_q));

	assign sts.full       = (cnt_q == CW'(TABLE_DEPTH));
	assign sts.sweep_last = (sweep_q == PAIR_W'(PAIR_SLOTS - 1));
	assign sts.slot_hit   = slot_hit;
	assign sts.scan_more  = (scan_q != '0);

	assign result = res_q;

	// entry store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.ins_rd)
			ent_mem[idx_q] <= '{key: key_q, len: len_q, exact: exact_q, ent: ent_q};
		ent_rd_q <= ent_mem[ent_ra];
	end

	// pair slot store
	always_ff @(posedge clk) begin
		if (ctl.sweep)
			slot_mem[sweep_q] <= SLOT_UNUSED;
		else if (ctl.ins_wr && len_q >= 4'd2)
			slot_mem[pair] <= (slot_rd_q == SLOT_UNUSED) ? {2'b00, idx_q} : SLOT_AMBIG;
		slot_rd_q <= slot_mem[pair];
	end

	// command latch and slot check registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q    <= cmd.opcode;
			len_q   <= len_n;
			key_q   <= cmd.key_chars & char_mask(len_n);
			exact_q <= cmd.exact_only;
			ent_q   <= ent_n;
			full_q  <= (cnt_q == CW'(TABLE_DEPTH));
			idx_q   <= cnt_q[IW-1:0];
		end
		if (ctl.q_ent) begin
			slot_pre_q <= (len_q >= 4'd2) && (slot_rd_q[SW-1:SW-2] == 2'b00) &&
				({1'b0, slot_rd_q[IW-1:0]} < cnt_q);
			slot_w_q   <= slot_rd_q[IW-1:0];
		end
		if (ctl.q_chk) begin
			slot_hit_q <= slot_hit;
			slot_ent_q <= ent_rd_q.ent;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sweep_q <= '0;
			scan_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (ctl.load && cmd.opcode == OP_CLEAR)
				cnt_q <= '0;
			else if (ctl.ins_wr)
				cnt_q <= cnt_q + CW'(1);
			if (ctl.sweep)
				sweep_q <= sts.sweep_last ? '0 : sweep_q + PAIR_W'(1);
			if (ctl.q_chk)
				scan_q <= cnt_q;
			else if (ctl.scan && scan_q != '0)
				scan_q <= scan_q - CW'(1);
			vld_s1 <= ctl.scan && (scan_q != '0);
		end
	end

	// scan evaluation, newest entry first
	always_ff @(posedge clk) begin
		idx_s1 <= ent_ra;
		if (ctl.q_chk) begin
			whole_hit_q <= 1'b0;
			for (int l = 0; l < NL; l++)
				sfound_q[l] <= 1'b0;
		end else if (vld_s1) begin
			if (!whole_hit_q && ent_rd_q.len == len_q && ent_rd_q.key == key_q) begin
				whole_hit_q <= 1'b1;
				whole_idx_q <= idx_s1;
				whole_ent_q <= ent_rd_q.ent;
			end
			for (int l = 0; l < NL; l++) begin
				if (!sfound_q[l] && 4'(l + 1) < len_q && ent_rd_q.len == 4'(l + 1) &&
					ent_rd_q.key == (key_q & char_mask(4'(l + 1)))) begin
					sfound_q[l] <= 1'b1;
					sexact_q[l] <= ent_rd_q.exact;
					sidx_q[l]   <= idx_s1;
					sent_q[l]   <= ent_rd_q.ent;
				end
			end
		end
	end

	// result selection
	always_comb begin
		res_d = '0;
		case (op_q)
			OP_INSERT: begin
				if (full_q) begin
					res_d.status = ST_FULL;
				end else begin
					res_d.entry_index = 12'(32'(idx_q));
					res_d.entity_out  = ent_q;
				end
			end
			OP_QUERY: begin
				res_d.status = ST_NOTFOUND;
				for (int l = 0; l < NL; l++) begin
					if (sfound_q[l] && !sexact_q[l]) begin
						res_d.status      = ST_OK;
						res_d.match_kind  = KIND_SHORT;
						res_d.entry_index = 12'(32'(sidx_q[l]));
						res_d.entity_out  = sent_q[l];
					end
				end
				if (whole_hit_q) begin
					res_d.status      = ST_OK;
					res_d.match_kind  = KIND_WHOLE;
					res_d.entry_index = 12'(32'(whole_idx_q));
					res_d.entity_out  = whole_ent_q;
				end
				if (slot_hit_q) begin
					res_d.status      = ST_OK;
					res_d.match_kind  = KIND_PAIR;
					res_d.entry_index = 12'(32'(slot_w_q));
					res_d.entity_out  = slot_ent_q;
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.finish)
			res_q <= res_d;
	end

endmodule

// ===== verif/cplm_checker.sv =====
// checker for the call sign prefix match engine: predicts each result beat and compares
// depends on cplm_pkg
`timescale 1ns / 100ps
module cplm_checker import cplm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic done,
	input  res_t result,
	output int   fail_count,
	output int   pending
);
	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [31:0] SLOT_FREE = 32'hFFFF_FFFF;
	localparam logic [31:0] SLOT_MULTI = 32'hFFFF_FFFE;

	logic [63:0] t_key [DEPTH];
	logic [3:0]  t_len [DEPTH];
	logic        t_exact [DEPTH];
	logic [9:0]  t_ent [DEPTH];
	int          t_count;
	logic [31:0] slots [PAIR_SLOTS];
	res_t        answers [$];

	function automatic logic [63:0] byte_mask(input int n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic int digit36(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "A" && c <= "Z")
			return c - "A" + 10;
		return 0;
	endfunction

	function automatic int newest_with(input logic [63:0] k, input int n);
		for (int i = t_count - 1; i >= 0; i--)
			if (t_len[i] == n && t_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic res_t mk(input logic [1:0] s, input logic [1:0] kd, input int idx,
			input logic [9:0] e);
		res_t r;
		r.status = s;
		r.match_kind = kd;
		r.entry_index = 12'(idx);
		r.entity_out = e;
		return r;
	endfunction

	// model one command beat
	function automatic res_t best_match(input cmd_t c);
		int n, p, w, hit;
		logic [63:0] k;
		logic [9:0] e;
		n = (c.key_length > 8) ? 8 : c.key_length;
		k = c.key_chars & byte_mask(n);
		p = digit36(k[7:0]) + 36 * digit36(k[15:8]);
		case (c.opcode)
			OP_CLEAR: begin
				t_count = 0;
				foreach (slots[i]) slots[i] = SLOT_FREE;
				return mk(ST_OK, KIND_PAIR, 0, 0);
			end
			OP_INSERT: begin
				if (t_count >= DEPTH)
					return mk(ST_FULL, KIND_PAIR, 0, 0);
				e = (c.entity >= ENTITY_COUNT_DEF) ? 10'(ENTITY_COUNT_DEF - 1) : c.entity;
				t_key[t_count] = k;
				t_len[t_count] = 4'(n);
				t_exact[t_count] = c.exact_only;
				t_ent[t_count] = e;
				if (n >= 2)
					slots[p] = (slots[p] == SLOT_FREE) ? 32'(t_count) : SLOT_MULTI;
				t_count++;
				return mk(ST_OK, KIND_PAIR, t_count - 1, e);
			end
			OP_QUERY: begin
				if (n >= 2 && slots[p] < 32'(t_count)) begin
					w = int'(slots[p]);
					if (!t_exact[w] || (t_len[w] == n && t_key[w] == k))
						return mk(ST_OK, KIND_PAIR, w, t_ent[w]);
				end
				hit = newest_with(k, n);
				if (hit >= 0)
					return mk(ST_OK, KIND_WHOLE, hit, t_ent[hit]);
				for (int l = n - 1; l >= 1; l--) begin
					hit = newest_with(k & byte_mask(l), l);
					if (hit >= 0 && !t_exact[hit])
						return mk(ST_OK, KIND_SHORT, hit, t_ent[hit]);
				end
				return mk(ST_NOTFOUND, KIND_PAIR, 0, 0);
			end
			default: return mk(ST_OK, KIND_PAIR, 0, 0);
		endcase
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		t_count = 0;
		foreach (slots[i]) slots[i] = SLOT_FREE;
	end

	// predict on each accepted command beat, compare each result beat
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (answers.size() == 0)
					report("result beat with nothing expected");
				else begin
					want = answers.pop_front();
					if (result.status !== want.status)
						report($sformatf("status %0d want %0d", result.status, want.status));
					if (result.match_kind !== want.match_kind)
						report($sformatf("kind %0d want %0d", result.match_kind, want.match_kind));
					if (result.entry_index !== want.entry_index)
						report($sformatf("index %0d want %0d", result.entry_index,
							want.entry_index));
					if (result.entity_out !== want.entity_out)
						report($sformatf("entity %0d want %0d", result.entity_out,
							want.entity_out));
				end
			end
			if (start && !busy)
				answers.push_back(best_match(cmd));
		end
		pending = answers.size();
	end
endmodule

// ===== verif/tb.sv =====
// testbench top for the call sign prefix match engine: stimulus and verdict
// depends on cplm_pkg, cplm_checker, callsign_prefix_longest_match
`timescale 1ns / 100ps
module tb;
	import cplm_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 1;
	logic start = 0;
	logic busy, done;
	cmd_t cmd = '0;
	res_t result;
	int   fail_count, pending;
	int   idle_pct = 29;
	int   quiet = 0;
	logic [7:0] alphabet [6] = '{"A", "B", "1", "2", "K", "/"};

	always #1 clk = ~clk;

	callsign_prefix_longest_match uut (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result));

	cplm_checker chk (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending));

	// watchdog on cycles with no beat
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// hand one command beat over, with a random gap first; start stays up until the
	// next gap or beat so it is driven once per edge
	task automatic send(input logic [1:0] op, input logic [63:0] k, input logic [3:0] n,
			input logic ex, input logic [9:0] e);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		cmd <= '{opcode: op, key_chars: k, key_length: n, exact_only: ex, entity: e};
		start <= 1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// short call sign from a small alphabet so keys collide often
	function automatic logic [63:0] rand_call(input int n);
		logic [63:0] k;
		k = $urandom() | (64'($urandom()) << 32);
		for (int i = 0; i < n; i++)
			k[8*i +: 8] = alphabet[$urandom_range(5)];
		return k;
	endfunction

	initial begin
		int n;
		arst_n <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed beats
		send(OP_QUERY, "KA", 2, 0, 0);
		send(OP_INSERT, 64'h0000_0000_0000_4B41, 2, 0, 10'd5);
		send(OP_INSERT, "AK", 2, 1, 10'h3FF);
		send(OP_QUERY, 64'h0000_0000_0000_4B41, 2, 0, 0);
		send(OP_QUERY, 64'h0000_0000_3131_4B41, 4, 0, 0);
		send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 0, 10'd1);
		send(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 0, 0);
		send(OP_QUERY, 64'h0000_0000_0000_4B41, 4'd1, 0, 0);
		send(OP_INSERT, 64'h4B, 1, 0, 10'd7);
		send(OP_QUERY, 64'h0000_0000_0032_5A4B, 3, 0, 0);
		send(OP_INSERT, 64'h0000_0000_0000_3141, 2, 0, 10'd9);
		send(OP_INSERT, 64'h0000_0000_0032_3141, 3, 1, 10'd3);
		send(OP_QUERY, 64'h0000_0000_0032_3141, 3, 0, 0);
		send(OP_QUERY, 64'h0000_0000_3332_3141, 4, 0, 0);
		send(2'd3, '1, 4'hF, 1, '1);
		send(OP_QUERY, 64'h0, 0, 0, 0);
		send(OP_CLEAR, '1, 4'hF, 1, '1);
		send(OP_QUERY, 64'h0000_0000_0000_4B41, 2, 0, 0);
		// random beats in three idling phases
		for (int i = 0; i < 122; i++) begin
			if (i == 41) idle_pct = 85;
			if (i == 82) idle_pct = 0;
			n = $urandom_range(8);
			case ($urandom_range(19))
				0: send(OP_CLEAR, rand_call(n), 4'($urandom()), 1'($urandom()),
					10'($urandom()));
				1: send(2'($urandom()), {$urandom(), $urandom()}, 4'($urandom()),
					1'($urandom()), 10'($urandom()));
				2, 3, 4, 5, 6, 7, 8: send(OP_INSERT, rand_call(n),
					($urandom_range(9) == 0) ? 4'($urandom()) : 4'(n),
					$urandom_range(3) == 0, 10'($urandom()));
				default: send(OP_QUERY, rand_call(n), 4'(n), 1'($urandom()),
					10'($urandom()));
			endcase
		end
		start <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== callsign_prefix_longest_match.f =====
+incdir+design
design/cplm_pkg.sv
design/cplm_ctrl.sv
design/cplm_datapath.sv
design/callsign_prefix_longest_match.sv
verif/cplm_checker.sv
verif/tb.sv
